// File: hw/rtl/bdb_pkg.sv
// bdb_pkg: shared types and constants for the button debouncer
// no dependencies; compiled first
`default_nettype none

package bdb_pkg;

  // fixed field widths of the sample and result items and of the debounce time
  localparam int BTN_W     = 3;
  localparam int STAMP_W   = 32;
  localparam int DBNC_W    = 16;

  // debounce time after reset, in milliseconds
  localparam logic [DBNC_W-1:0] DBNC_RESET = 16'd10;

  // item kinds
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_INIT   = 1'b1;

  // control fanned out to every debounce unit
  typedef struct packed {
    logic step;  // an item is accepted this cycle
    logic init;  // the item loads state from the raw levels
  } bdb_ctrl_t;

  // level reported by a debounce unit to the merge stage
  typedef struct packed {
    logic cur;   // stable level before the item
    logic nxt;   // stable level after the item
  } bdb_level_t;

  // one result item
  typedef struct packed {
    logic [BTN_W-1:0] stable_buttons;
    logic             stable_multi;
    logic             buttons_changed;
    logic [BTN_W-1:0] new_presses;
    logic             multi_new_press;
  } bdb_result_t;

endpackage

`default_nettype wire

// File: hw/rtl/bdb_if.sv
// bdb_if: valid/ready channels for sample items and result items
// depends on bdb_pkg
`default_nettype none

interface bdb_sample_if;
  import bdb_pkg::*;

  logic               valid;
  logic               ready;
  logic               req_type;
  logic [BTN_W-1:0]   raw_buttons;
  logic               raw_multi_host;
  logic [STAMP_W-1:0] now_ms;

  modport source (output valid, req_type, raw_buttons, raw_multi_host, now_ms,
                  input ready);
  modport sink (input valid, req_type, raw_buttons, raw_multi_host, now_ms,
                output ready);
endinterface

interface bdb_result_if;
  import bdb_pkg::*;

  logic             valid;
  logic             ready;
  logic [BTN_W-1:0] stable_buttons;
  logic             stable_multi;
  logic             buttons_changed;
  logic [BTN_W-1:0] new_presses;
  logic             multi_new_press;

  modport source (output valid, stable_buttons, stable_multi, buttons_changed,
                  new_presses, multi_new_press, input ready);
  modport sink (input valid, stable_buttons, stable_multi, buttons_changed,
                new_presses, multi_new_press, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/bdb_lane.sv
// bdb_lane: asymmetric debounce for one mouse button
// press taken at once, release only after the debounce time; uses bdb_pkg
`default_nettype none

module bdb_lane #(
  parameter int TIME_WIDTH = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire bdb_pkg::bdb_ctrl_t        ctrl,
  input  wire logic                      raw,
  input  wire logic [TIME_WIDTH-1:0]     now,
  input  wire logic [bdb_pkg::DBNC_W-1:0] dbnc_time,
  output      bdb_pkg::bdb_level_t       level
);
  import bdb_pkg::*;

  localparam int CMP_W = (TIME_WIDTH > DBNC_W) ? TIME_WIDTH : DBNC_W;

  logic                  pressed;
  logic                  pressed_next;
  logic                  pending;
  logic                  pending_next;
  logic [TIME_WIDTH-1:0] start;
  logic [TIME_WIDTH-1:0] start_next;
  logic [TIME_WIDTH-1:0] diff;
  logic                  elapsed;

  // time since the contact opened, modulo the timer range
  assign diff    = now - start;
  assign elapsed = CMP_W'(diff) >= CMP_W'(dbnc_time);

  // press wins at once, release waits for the timer
  always_comb begin
    pressed_next = pressed;
    pending_next = pending;
    start_next   = start;
    if (ctrl.init) begin
      pressed_next = raw;
      pending_next = 1'b0;
      start_next   = '0;
    end else if (raw) begin
      pending_next = 1'b0;
      pressed_next = 1'b1;
    end else if (pressed) begin
      if (!pending) begin
        pending_next = 1'b1;
        start_next   = now;
      end else if (elapsed) begin
        pressed_next = 1'b0;
        pending_next = 1'b0;
      end
    end else begin
      pending_next = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pressed <= 1'b0;
      pending <= 1'b0;
    end else if (ctrl.step) begin
      pressed <= pressed_next;
      pending <= pending_next;
    end
  end

  // release start time, only read while a release is pending
  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      start <= start_next;
    end
  end

  assign level.cur = pressed;
  assign level.nxt = pressed_next;

  // a release timer only runs for a button held pressed
  a_pending_needs_press: assert property (@(posedge clk) disable iff (rst)
    pending |-> pressed)
    else $error("release pending on a released button");

endmodule

`default_nettype wire

// File: hw/rtl/bdb_multi.sv
// bdb_multi: symmetric settle-time debounce for the multi-host button
// depends on bdb_pkg
`default_nettype none

module bdb_multi #(
  parameter int TIME_WIDTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire bdb_pkg::bdb_ctrl_t         ctrl,
  input  wire logic                       raw,
  input  wire logic [TIME_WIDTH-1:0]      now,
  input  wire logic [bdb_pkg::DBNC_W-1:0] dbnc_time,
  output      bdb_pkg::bdb_level_t        level
);
  import bdb_pkg::*;

  localparam int CMP_W = (TIME_WIDTH > DBNC_W) ? TIME_WIDTH : DBNC_W;

  logic                  stable;
  logic                  stable_next;
  logic                  last_raw;
  logic                  last_raw_next;
  logic [TIME_WIDTH-1:0] change_time;
  logic [TIME_WIDTH-1:0] change_time_next;
  logic [TIME_WIDTH-1:0] diff;
  logic                  elapsed;

  // raw edge or an initialize item restarts the settle timer
  always_comb begin
    last_raw_next    = last_raw;
    change_time_next = change_time;
    if (ctrl.init || (raw != last_raw)) begin
      last_raw_next    = raw;
      change_time_next = now;
    end
  end

  assign diff    = now - change_time_next;
  assign elapsed = CMP_W'(diff) >= CMP_W'(dbnc_time);

  // take the raw level once it has settled, or at once on an initialize item
  always_comb begin
    stable_next = stable;
    if (ctrl.init || elapsed) begin
      stable_next = raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable      <= 1'b0;
      last_raw    <= 1'b0;
      change_time <= '0;
    end else if (ctrl.step) begin
      stable      <= stable_next;
      last_raw    <= last_raw_next;
      change_time <= change_time_next;
    end
  end

  assign level.cur = stable;
  assign level.nxt = stable_next;

endmodule

`default_nettype wire

// File: hw/rtl/button_debounce_asymmetric.sv
// button_debounce_asymmetric: one lane per mouse button plus a multi-host unit,
// a merge stage and a two-entry output buffer; uses bdb_pkg, bdb_if, bdb_lane, bdb_multi
// an accepted sample item's result is registered into the output register, or into the skid entry if it is held
// throughput: one item per cycle while the skid entry is empty; each lane updates its state on each accepted item
// the two-entry output buffer keeps taking items while one result waits
// reset: all buttons released, no release pending, multi-host timer zero, debounce time 10 ms
`default_nettype none

module button_debounce_asymmetric #(
  parameter int NUM_BUTTONS = 3,
  parameter int TIME_WIDTH  = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_wr_en,
  input  wire logic [bdb_pkg::DBNC_W-1:0] cfg_wr_data,
  bdb_sample_if.sink                      sample_in,
  bdb_result_if.source                    result_out
);
  import bdb_pkg::*;

  localparam int PAD_W = (NUM_BUTTONS > BTN_W) ? NUM_BUTTONS : BTN_W;

  logic [DBNC_W-1:0]      dbnc_time;
  bdb_ctrl_t              ctrl;
  logic                   accept;
  logic                   take;
  logic [TIME_WIDTH-1:0]  now;
  logic [PAD_W-1:0]       raw_pad;
  bdb_level_t             lane_level [NUM_BUTTONS];
  bdb_level_t             multi_level;
  logic [NUM_BUTTONS-1:0] btn_cur;
  logic [NUM_BUTTONS-1:0] btn_nxt;
  logic [PAD_W-1:0]       nxt_pad;
  logic [PAD_W-1:0]       rise_pad;
  bdb_result_t            res;

  logic                   out_vld;
  logic                   out_vld_next;
  bdb_result_t            out_data;
  bdb_result_t            out_data_next;
  logic                   skid_vld;
  logic                   skid_vld_next;
  bdb_result_t            skid_data;
  bdb_result_t            skid_data_next;

  // debounce time register
  always_ff @(posedge clk) begin
    if (rst) begin
      dbnc_time <= DBNC_RESET;
    end else if (cfg_wr_en) begin
      dbnc_time <= cfg_wr_data;
    end
  end

  // input handshake and per-item control
  assign sample_in.ready = !skid_vld;
  assign accept          = sample_in.valid && !skid_vld;
  assign ctrl.step       = accept;
  assign ctrl.init       = (sample_in.req_type == REQ_INIT);
  assign now             = sample_in.now_ms[TIME_WIDTH-1:0];
  assign raw_pad         = PAD_W'(sample_in.raw_buttons);

  // one debounce lane per mouse button
  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
    bdb_lane #(
      .TIME_WIDTH (TIME_WIDTH)
    ) u_lane (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .raw       (raw_pad[i]),
      .now       (now),
      .dbnc_time (dbnc_time),
      .level     (lane_level[i])
    );
    assign btn_cur[i] = lane_level[i].cur;
    assign btn_nxt[i] = lane_level[i].nxt;
  end

  bdb_multi #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_multi (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .raw       (sample_in.raw_multi_host),
    .now       (now),
    .dbnc_time (dbnc_time),
    .level     (multi_level)
  );

  // merge lane levels into one result; initialize reports no change
  assign nxt_pad  = PAD_W'(btn_nxt);
  assign rise_pad = PAD_W'(btn_nxt & ~btn_cur);

  always_comb begin
    res.stable_buttons  = nxt_pad[BTN_W-1:0];
    res.stable_multi    = multi_level.nxt;
    res.buttons_changed = 1'b0;
    res.new_presses     = '0;
    res.multi_new_press = 1'b0;
    if (!ctrl.init) begin
      res.buttons_changed = (btn_nxt != btn_cur);
      res.new_presses     = rise_pad[BTN_W-1:0];
      res.multi_new_press = multi_level.nxt && !multi_level.cur;
    end
  end

  // two-entry output buffer
  assign take = out_vld && result_out.ready;

  always_comb begin
    out_vld_next   = out_vld;
    out_data_next  = out_data;
    skid_vld_next  = skid_vld;
    skid_data_next = skid_data;
    if (take) begin
      if (skid_vld) begin
        out_data_next = skid_data;
        skid_vld_next = 1'b0;
      end else begin
        out_vld_next = 1'b0;
      end
    end
    if (accept) begin
      if (!out_vld_next) begin
        out_vld_next  = 1'b1;
        out_data_next = res;
      end else begin
        skid_vld_next  = 1'b1;
        skid_data_next = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld  <= 1'b0;
      skid_vld <= 1'b0;
    end else begin
      out_vld  <= out_vld_next;
      skid_vld <= skid_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    out_data  <= out_data_next;
    skid_data <= skid_data_next;
  end

  assign result_out.valid           = out_vld;
  assign result_out.stable_buttons  = out_data.stable_buttons;
  assign result_out.stable_multi    = out_data.stable_multi;
  assign result_out.buttons_changed = out_data.buttons_changed;
  assign result_out.new_presses     = out_data.new_presses;
  assign result_out.multi_new_press = out_data.multi_new_press;

  // skid entry only fills behind an occupied output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_vld |-> out_vld)
    else $error("skid entry held with empty output register");

  // skid entry is only loaded while the output stalls
  a_skid_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_vld) |-> $past(out_vld && !result_out.ready))
    else $error("skid entry loaded without a stall");

  // a new press is always part of the stable levels
  a_press_is_stable: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> ((out_data.new_presses & ~out_data.stable_buttons) == '0))
    else $error("new press on a released button");

  // new presses imply a change of the stable buttons
  a_press_is_change: assert property (@(posedge clk) disable iff (rst)
    (out_vld && !out_data.buttons_changed) |-> (out_data.new_presses == '0))
    else $error("new press without a change flag");

endmodule

`default_nettype wire

// File: test/testbench.sv
// testbench for button_debounce_asymmetric: directed sample table, then random phases
// depends on bdb_pkg, bdb_if and the debouncer rtl; results checked against a local predictor
`default_nettype none

module testbench;
  import bdb_pkg::*;

  localparam int N_DIRECTED  = 19;
  localparam int N_PHASES    = 8;
  localparam int PHASE_ITEMS = 140;
  localparam int HOLD_CYCLES = 60;
  localparam int STALL_LIMIT = 1000;

  // one row of the directed table
  typedef struct packed {
    logic               kind;
    logic [BTN_W-1:0]   btns;
    logic               mh;
    logic [STAMP_W-1:0] stamp;
    logic               typed;
    bdb_result_t        want;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wr_en = 1'b0;
  logic [DBNC_W-1:0] cfg_wr_data = '0;

  bdb_sample_if sample_bus ();
  bdb_result_if result_bus ();

  button_debounce_asymmetric #(
    .NUM_BUTTONS(BTN_W),
    .TIME_WIDTH (STAMP_W)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .sample_in  (sample_bus),
    .result_out (result_bus)
  );

  // predictor state, reset values
  logic [DBNC_W-1:0]  dbnc_now = DBNC_RESET;
  logic [BTN_W-1:0]   st_pressed = '0;
  logic [BTN_W-1:0]   st_pend = '0;
  logic [STAMP_W-1:0] st_rel_at [0:BTN_W-1] = '{default: '0};
  logic               st_multi = 1'b0;
  logic               st_mlast = 1'b0;
  logic [STAMP_W-1:0] st_mtime = '0;

  // expected results and bookkeeping
  bdb_result_t due_results [$];
  logic        cur_typed = 1'b0;
  bdb_result_t cur_want = '0;
  int          n_items = 0;
  int          n_checked = 0;
  int          n_err = 0;
  int          n_holds = 0;
  int          idle_cycles = 0;

  // idling control for sender and receiver
  logic no_idle = 1'b0;
  logic hold_req = 1'b0;
  int   burst_left = 0;
  int   ready_run = 0;

  stim_row_t         dir_rows [0:N_DIRECTED-1];
  logic [DBNC_W-1:0] dbnc_plan [0:N_PHASES-1];

  // clock, period 10
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // time since a start point has reached the debounce time
  function automatic logic settled(input logic [STAMP_W-1:0] now,
                                   input logic [STAMP_W-1:0] since);
    logic [STAMP_W-1:0] span;
    span = now - since;
    return span >= {{(STAMP_W-DBNC_W){1'b0}}, dbnc_now};
  endfunction

  // advance debouncer state by one sample and return the result it produces
  function automatic bdb_result_t debounce_next(input logic kind,
                                                input logic [BTN_W-1:0] raw,
                                                input logic rawm,
                                                input logic [STAMP_W-1:0] now);
    logic [BTN_W-1:0] was_btn;
    logic             was_m;
    bdb_result_t      r;
    was_btn = st_pressed;
    was_m   = st_multi;
    if (kind == REQ_INIT) begin
      st_pressed = raw;
      st_pend    = '0;
      for (int i = 0; i < BTN_W; i++) st_rel_at[i] = '0;
      st_multi = rawm;
      st_mlast = rawm;
      st_mtime = now;
      was_btn  = raw;
      was_m    = rawm;
    end else begin
      // press at once, release only after the contact stays open
      for (int i = 0; i < BTN_W; i++) begin
        if (raw[i]) begin
          st_pend[i]    = 1'b0;
          st_pressed[i] = 1'b1;
        end else if (st_pressed[i]) begin
          if (!st_pend[i]) begin
            st_pend[i]   = 1'b1;
            st_rel_at[i] = now;
          end else if (settled(now, st_rel_at[i])) begin
            st_pressed[i] = 1'b0;
            st_pend[i]    = 1'b0;
          end
        end else begin
          st_pend[i] = 1'b0;
        end
      end
      // multi-host: symmetric settle time
      if (rawm != st_mlast) begin
        st_mlast = rawm;
        st_mtime = now;
      end
      if (settled(now, st_mtime)) st_multi = rawm;
    end
    r.stable_buttons  = st_pressed;
    r.stable_multi    = st_multi;
    r.buttons_changed = (st_pressed != was_btn);
    r.new_presses     = st_pressed & ~was_btn;
    r.multi_new_press = st_multi & ~was_m;
    return r;
  endfunction

  // sender gap: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || burst_left > 0) return 0;
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // time step between samples, scaled to the debounce time
  function automatic logic [STAMP_W-1:0] stamp_advance(input logic [DBNC_W-1:0] span);
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 85) return $urandom_range(0, 2 * int'(span) + 2);
    if (r < 95) return {{(STAMP_W-DBNC_W){1'b0}}, span};
    return $urandom;
  endfunction

  // offer one item and wait until it is taken
  task automatic send_sample(input logic kind, input logic [BTN_W-1:0] btns,
                             input logic mh, input logic [STAMP_W-1:0] stamp,
                             input logic typed, input bdb_result_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      sample_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_bus.req_type       = kind;
    sample_bus.raw_buttons    = btns;
    sample_bus.raw_multi_host = mh;
    sample_bus.now_ms         = stamp;
    cur_typed                 = typed;
    cur_want                  = want;
    sample_bus.valid          = 1'b1;
    @(posedge clk);
    while (!sample_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // stop sending and wait for every expected result
  task automatic wait_results_done();
    sample_bus.valid = 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // write the debounce time while the block is idle
  task automatic write_debounce(input logic [DBNC_W-1:0] value);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    dbnc_now  = value;
  endtask

  // receiver: random ready runs, quiet stretches and one long hold-off
  initial begin
    result_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req         = 1'b0;
        result_bus.ready = 1'b0;
        n_holds++;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (no_idle) begin
        result_bus.ready = 1'b1;
      end else if (ready_run > 0) begin
        ready_run--;
      end else begin
        result_bus.ready = ($urandom_range(0, 99) < 70);
        if (result_bus.ready) ready_run = $urandom_range(0, 15);
        else if ($urandom_range(0, 9) < 8) ready_run = $urandom_range(0, 2);
        else ready_run = $urandom_range(5, 25);
      end
    end
  end

  // predict on accepted items, check accepted results, watch for a hang
  always @(posedge clk) begin
    bdb_result_t want;
    bdb_result_t got;
    logic        moved;
    moved = 1'b0;
    if (!rst && sample_bus.valid && sample_bus.ready) begin
      want = debounce_next(sample_bus.req_type, sample_bus.raw_buttons,
                           sample_bus.raw_multi_host, sample_bus.now_ms);
      if (cur_typed) want = cur_want;
      due_results.push_back(want);
      n_items++;
      moved = 1'b1;
    end
    if (!rst && result_bus.valid && result_bus.ready) begin
      got = {result_bus.stable_buttons, result_bus.stable_multi, result_bus.buttons_changed,
             result_bus.new_presses, result_bus.multi_new_press};
      moved = 1'b1;
      if (due_results.size() == 0) begin
        n_err++;
        if (n_err <= 10)
          $display("result with nothing expected: btn=%b multi=%b chg=%b new=%b mnew=%b",
                   got.stable_buttons, got.stable_multi, got.buttons_changed,
                   got.new_presses, got.multi_new_press);
      end else begin
        want = due_results.pop_front();
        n_checked++;
        if (got !== want) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch at result %0d: exp %b/%b/%b/%b/%b got %b/%b/%b/%b/%b",
                     n_checked,
                     want.stable_buttons, want.stable_multi, want.buttons_changed,
                     want.new_presses, want.multi_new_press,
                     got.stable_buttons, got.stable_multi, got.buttons_changed,
                     got.new_presses, got.multi_new_press);
        end
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL button_debounce_asymmetric");
      $finish;
    end
  end

  // main sequence
  initial begin
    logic [BTN_W-1:0]   btns;
    logic               mh;
    logic               kind;
    logic [STAMP_W-1:0] stamp;
    logic [BTN_W-1:0]   btn_goal;
    logic               mh_goal;

    sample_bus.valid          = 1'b0;
    sample_bus.req_type       = REQ_SAMPLE;
    sample_bus.raw_buttons    = '0;
    sample_bus.raw_multi_host = 1'b0;
    sample_bus.now_ms         = '0;

    // kind, buttons, multi, stamp, typed, expected result
    dir_rows = '{
      // quiet start after reset
      '{REQ_SAMPLE, 3'b000, 1'b0, 32'd0,          1'b1, {3'b000, 1'b0, 1'b0, 3'b000, 1'b0}},
      // all pressed at once, multi starts settling
      '{REQ_SAMPLE, 3'b111, 1'b1, 32'd5,          1'b1, {3'b111, 1'b0, 1'b1, 3'b111, 1'b0}},
      // releases start, multi settles at exactly the debounce time
      '{REQ_SAMPLE, 3'b000, 1'b1, 32'd10,         1'b0, 9'd0},
      '{REQ_SAMPLE, 3'b000, 1'b1, 32'd15,         1'b0, 9'd0},
      // right re-pressed cancels its release
      '{REQ_SAMPLE, 3'b010, 1'b1, 32'd18,         1'b0, 9'd0},
      '{REQ_SAMPLE, 3'b000, 1'b1, 32'd28,         1'b0, 9'd0},
      '{REQ_SAMPLE, 3'b000, 1'b1, 32'd37,         1'b0, 9'd0},
      '{REQ_SAMPLE, 3'b000, 1'b0, 32'd38,         1'b0, 9'd0},
      // initialize near the top of the time range, then wrap
      '{REQ_INIT,   3'b101, 1'b1, 32'hFFFF_FFF0,  1'b1, {3'b101, 1'b1, 1'b0, 3'b000, 1'b0}},
      '{REQ_SAMPLE, 3'b000, 1'b0, 32'hFFFF_FFF8,  1'b0, 9'd0},
      '{REQ_SAMPLE, 3'b000, 1'b0, 32'h0000_0002,  1'b0, 9'd0},
      // zero timestamp as a normal release start
      '{REQ_INIT,   3'b000, 1'b0, 32'd0,          1'b1, {3'b000, 1'b0, 1'b0, 3'b000, 1'b0}},
      '{REQ_SAMPLE, 3'b001, 1'b0, 32'd0,          1'b1, {3'b001, 1'b0, 1'b1, 3'b001, 1'b0}},
      '{REQ_SAMPLE, 3'b000, 1'b0, 32'd0,          1'b0, 9'd0},
      '{REQ_SAMPLE, 3'b000, 1'b0, 32'd10,         1'b0, 9'd0},
      // extreme stamps and half-range difference
      '{REQ_INIT,   3'b111, 1'b1, 32'h8000_0000,  1'b1, {3'b111, 1'b1, 1'b0, 3'b000, 1'b0}},
      '{REQ_SAMPLE, 3'b000, 1'b1, 32'hFFFF_FFFF,  1'b0, 9'd0},
      '{REQ_SAMPLE, 3'b000, 1'b0, 32'h7FFF_FFFF,  1'b0, 9'd0},
      '{REQ_SAMPLE, 3'b111, 1'b1, 32'hFFFF_FFFF,  1'b0, 9'd0}
    };
    dbnc_plan = '{16'd0, 16'd1, 16'd3, 16'hFFFF, 16'd10, 16'd2, 16'd250, 16'd7};

    // hold reset, then release it
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // directed table at the reset debounce time
    for (int k = 0; k < N_DIRECTED; k++)
      send_sample(dir_rows[k].kind, dir_rows[k].btns, dir_rows[k].mh, dir_rows[k].stamp,
                  dir_rows[k].typed, dir_rows[k].want);
    wait_results_done();

    // random phases, one debounce time each
    for (int p = 0; p < N_PHASES; p++) begin
      write_debounce(dbnc_plan[p]);
      stamp    = $urandom;
      btn_goal = '0;
      mh_goal  = 1'b0;
      no_idle  = p[0];
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == 30) no_idle = 1'b0;
        // long receiver hold-off while the sender keeps going
        if (p == 2 && k == 40) begin
          hold_req   = 1'b1;
          burst_left = 40;
        end
        if (burst_left > 0) burst_left--;
        kind = ($urandom_range(0, 99) < 3) ? REQ_INIT : REQ_SAMPLE;
        if ($urandom_range(0, 99) < 5) begin
          // noise: levels and time at random
          btns  = BTN_W'($urandom);
          mh    = 1'($urandom);
          stamp = $urandom;
        end else begin
          // bouncing contacts around slowly changing levels
          stamp = stamp + stamp_advance(dbnc_now);
          for (int b = 0; b < BTN_W; b++) begin
            if ($urandom_range(0, 99) < 12) btn_goal[b] = ~btn_goal[b];
            btns[b] = ($urandom_range(0, 99) < 15) ? ~btn_goal[b] : btn_goal[b];
          end
          if ($urandom_range(0, 99) < 12) mh_goal = ~mh_goal;
          mh = ($urandom_range(0, 99) < 15) ? ~mh_goal : mh_goal;
        end
        send_sample(kind, btns, mh, stamp, 1'b0, '0);
      end
      wait_results_done();
    end

    repeat (5) @(negedge clk);
    if (due_results.size() != 0) n_err++;
    $display("run covered %0d sample items over %0d debounce settings incl. 0 and 65535",
             n_items, N_PHASES + 1);
    $display("%0d results checked, %0d receiver hold-offs, %0d mismatches",
             n_checked, n_holds, n_err);
    if (n_err == 0) begin
      $display("PASS button_debounce_asymmetric");
    end else begin
      $display("FAIL button_debounce_asymmetric");
    end
    $finish;
  end

endmodule

`default_nettype wire
